[sv/jrs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jrs_pkg
// Shared sizes, codes and types of the job row sorter.
// ----------------------------------------------------------------------------
package jrs_pkg;

  localparam int MAX_JOBS     = 16;
  localparam int MAX_MACHINES = 16;
  localparam int TIME_BITS    = 16;

  localparam int DEPTH      = MAX_JOBS * MAX_MACHINES;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ROW_W      = $clog2(MAX_JOBS);
  localparam int COL_W      = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int KEY_W      = TIME_BITS + COL_W;
  localparam int CNT_W      = 5;
  localparam int RULE_W     = 3;
  localparam int PLAN_W     = 8;
  localparam int IN_TIME_W  = 16;
  localparam int SRC_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SORT_RULE     = 2'd0,
    CFG_JOB_COUNT     = 2'd1,
    CFG_MACHINE_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [RULE_W-1:0] {
    RULE_KEEP     = 3'd0,
    RULE_SUM_ASC  = 3'd1,
    RULE_SUM_DESC = 3'd2,
    RULE_MIN_ASC  = 3'd3,
    RULE_MIN_DESC = 3'd4,
    RULE_MAX_ASC  = 3'd5,
    RULE_MAX_DESC = 3'd6
  } rule_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEYI,
    ST_RANK,
    ST_RESP
  } state_e;

  typedef struct packed {
    op_e                  op;
    logic [TIME_BITS-1:0] ptime;
    logic [PLAN_W-1:0]    plan;
  } item_t;

  // Queue link between front and back.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage : jrs_pkg
`default_nettype wire

[sv/jrs_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jrs_in_if / jrs_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface jrs_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] proc_time;
  logic [7:0]  plan_entry;
  modport source (output valid, func, proc_time, plan_entry, input ready);
  modport sink (input valid, func, proc_time, plan_entry, output ready);
endinterface : jrs_in_if

interface jrs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_time;
  logic [7:0]  out_plan;
  logic [3:0]  source_row;
  logic        last;
  logic        status;
  modport source (output valid, out_time, out_plan, source_row, last, status, input ready);
  modport sink (input valid, out_time, out_plan, source_row, last, status, output ready);
endinterface : jrs_out_if
`default_nettype wire

[sv/jrs_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule : jrs_ram
`default_nettype wire

[sv/jrs_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jrs_front
// Accepts input beats, decodes the function and queues them for the back end.
// ----------------------------------------------------------------------------
module jrs_front (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  jrs_in_if.sink      in_ch,
  output jrs_pkg::q_head_t head_o,
  input  wire logic   pop_i
);
  import jrs_pkg::*;

  item_t      entry_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  item_t      item_in;

  assign in_ch.ready = (cnt_q != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    item_in.op    = in_ch.func ? OP_FETCH : OP_LOAD;
    item_in.ptime = in_ch.proc_time[TIME_BITS-1:0];
    item_in.plan  = in_ch.plan_entry;
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = entry_q[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= item_in;
    end
  end
endmodule : jrs_front
`default_nettype wire

[sv/jrs_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jrs_back
// Stores the table, builds row keys, ranks rows and serves fetches.
// ----------------------------------------------------------------------------
module jrs_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire jrs_pkg::q_head_t           head_i,
  output logic                            pop_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [jrs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [jrs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  jrs_out_if.source                       out_ch
);
  import jrs_pkg::*;

  state_e st_q, st_d;

  logic [RULE_W-1:0] rule_q;
  logic [CNT_W-1:0]  jobs_q, machines_q;
  logic [CNT_W-1:0]  n_use, m_use, n_lastw, m_lastw;
  logic [ROW_W-1:0]  n_last;
  logic [COL_W-1:0]  m_last;
  logic              is_sum, is_min, is_max, is_desc;

  logic [ADDR_W-1:0] ld_addr_q, e_addr;
  logic [ROW_W-1:0]  ld_row_q, e_row;
  logic [COL_W-1:0]  ld_col_q, e_col;
  logic [KEY_W-1:0]  acc_q, acc_d, t_ext;
  logic              sorted_q;

  logic [KEY_W-1:0]  key_q [MAX_JOBS];
  logic [ROW_W-1:0]  order_q [MAX_JOBS];
  logic [KEY_W-1:0]  ki_q, key_rd;
  logic [ROW_W-1:0]  i_q, j_q, rank_q, rank_nx, place;
  logic              hit;

  logic [ROW_W-1:0]  f_row_q;
  logic [COL_W-1:0]  f_col_q;
  logic [ROW_W-1:0]  src;
  logic [ROW_W+CNT_W-1:0] prod;
  logic [ADDR_W-1:0] rd_addr;
  logic              f_last;
  logic [ROW_W-1:0]  src_q;
  logic              last_q;

  logic              out_free, do_load, do_fetch, do_nrdy;
  logic [TIME_BITS+PLAN_W-1:0] rdata;

  logic                 ov_q;
  logic [IN_TIME_W-1:0] o_time_q;
  logic [PLAN_W-1:0]    o_plan_q;
  logic [SRC_W-1:0]     o_src_q;
  logic                 o_last_q, o_stat_q;

  // Counts saturate into their legal ranges.
  always_comb begin
    if (jobs_q == '0) n_use = CNT_W'(1);
    else if (jobs_q > CNT_W'(MAX_JOBS)) n_use = CNT_W'(MAX_JOBS);
    else n_use = jobs_q;
    if (machines_q == '0) m_use = CNT_W'(1);
    else if (machines_q > CNT_W'(MAX_MACHINES)) m_use = CNT_W'(MAX_MACHINES);
    else m_use = machines_q;
    n_lastw = n_use - CNT_W'(1);
    m_lastw = m_use - CNT_W'(1);
    n_last  = n_lastw[ROW_W-1:0];
    m_last  = m_lastw[COL_W-1:0];
  end

  assign is_sum  = (rule_q == RULE_SUM_ASC) || (rule_q == RULE_SUM_DESC);
  assign is_min  = (rule_q == RULE_MIN_ASC) || (rule_q == RULE_MIN_DESC);
  assign is_max  = (rule_q == RULE_MAX_ASC) || (rule_q == RULE_MAX_DESC);
  assign is_desc = (rule_q == RULE_SUM_DESC) || (rule_q == RULE_MIN_DESC) ||
                   (rule_q == RULE_MAX_DESC);

  // A load after a finished table starts a new one.
  assign e_addr = sorted_q ? '0 : ld_addr_q;
  assign e_row  = sorted_q ? '0 : ld_row_q;
  assign e_col  = sorted_q ? '0 : ld_col_q;
  assign t_ext  = KEY_W'(head_i.item.ptime);

  always_comb begin
    if (!(is_sum || is_min || is_max)) acc_d = '0;
    else if (e_col == '0) acc_d = t_ext;
    else if (is_sum) acc_d = acc_q + t_ext;
    else if (is_min) acc_d = (t_ext < acc_q) ? t_ext : acc_q;
    else acc_d = (t_ext > acc_q) ? t_ext : acc_q;
  end

  // Rank compare: one stored key per cycle against the key of row i.
  assign key_rd  = key_q[(st_q == ST_KEYI) ? i_q : j_q];
  assign hit     = (key_rd < ki_q) || ((key_rd == ki_q) && (j_q < i_q));
  assign rank_nx = rank_q + ROW_W'(hit);
  assign place   = is_desc ? (n_last - rank_nx) : rank_nx;

  // Fetch address of the next sorted element.
  assign src     = order_q[f_row_q];
  assign prod    = src * m_use;
  assign rd_addr = prod[ADDR_W-1:0] + ADDR_W'(f_col_q);
  assign f_last  = (f_row_q == n_last) && (f_col_q == m_last);

  assign out_free = !ov_q || out_ch.ready;

  // Control strobes.
  always_comb begin
    do_load  = 1'b0;
    do_fetch = 1'b0;
    do_nrdy  = 1'b0;
    if ((st_q == ST_IDLE) && head_i.valid) begin
      if (head_i.item.op == OP_LOAD) do_load = 1'b1;
      else if (out_free) begin
        if (sorted_q) do_fetch = 1'b1;
        else do_nrdy = 1'b1;
      end
    end
    pop_o = do_load || do_fetch || do_nrdy;
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (do_load && (e_col == m_last) && (e_row == n_last)) st_d = ST_KEYI;
        else if (do_fetch) st_d = ST_RESP;
      end
      ST_KEYI: st_d = ST_RANK;
      ST_RANK: begin
        if (j_q == n_last) st_d = (i_q == n_last) ? ST_IDLE : ST_KEYI;
      end
      ST_RESP: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  jrs_ram #(.Width(TIME_BITS + PLAN_W), .Depth(DEPTH)) u_store (
    .clk_i  (clk_i),
    .we_i   (do_load),
    .waddr_i(e_addr),
    .wdata_i({head_i.item.ptime, head_i.item.plan}),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      rule_q     <= RULE_SUM_ASC;
      jobs_q     <= CNT_W'(16);
      machines_q <= CNT_W'(16);
      ld_addr_q  <= '0;
      ld_row_q   <= '0;
      ld_col_q   <= '0;
      sorted_q   <= 1'b0;
      f_row_q    <= '0;
      f_col_q    <= '0;
      i_q        <= '0;
      j_q        <= '0;
      rank_q     <= '0;
      ov_q       <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_ch.ready) ov_q <= 1'b0;
      if (cfg_we_i && ((cfg_idx_i == CFG_SORT_RULE) || (cfg_idx_i == CFG_JOB_COUNT) ||
                       (cfg_idx_i == CFG_MACHINE_COUNT))) begin
        if (cfg_idx_i == CFG_SORT_RULE) rule_q <= cfg_data_i[RULE_W-1:0];
        else if (cfg_idx_i == CFG_JOB_COUNT) jobs_q <= cfg_data_i;
        else machines_q <= cfg_data_i;
        ld_addr_q <= '0;
        ld_row_q  <= '0;
        ld_col_q  <= '0;
        sorted_q  <= 1'b0;
        f_row_q   <= '0;
        f_col_q   <= '0;
      end
      if (do_load) begin
        sorted_q  <= 1'b0;
        ld_addr_q <= e_addr + ADDR_W'(1);
        if (e_col == m_last) begin
          ld_col_q <= '0;
          ld_row_q <= e_row + ROW_W'(1);
          if (e_row == n_last) i_q <= '0;
        end else begin
          ld_col_q <= e_col + COL_W'(1);
          ld_row_q <= e_row;
        end
      end
      if (st_q == ST_KEYI) begin
        j_q    <= '0;
        rank_q <= '0;
      end
      if (st_q == ST_RANK) begin
        rank_q <= rank_nx;
        j_q    <= j_q + ROW_W'(1);
        if (j_q == n_last) begin
          i_q <= i_q + ROW_W'(1);
          if (i_q == n_last) begin
            sorted_q <= 1'b1;
            f_row_q  <= '0;
            f_col_q  <= '0;
          end
        end
      end
      if (do_fetch) begin
        if (f_last) begin
          f_row_q <= '0;
          f_col_q <= '0;
        end else if (f_col_q == m_last) begin
          f_col_q <= '0;
          f_row_q <= f_row_q + ROW_W'(1);
        end else begin
          f_col_q <= f_col_q + COL_W'(1);
        end
      end
      if (do_nrdy || (st_q == ST_RESP)) ov_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) acc_q <= acc_d;
    if (do_load && (e_col == m_last)) key_q[e_row] <= acc_d;
    if (st_q == ST_KEYI) ki_q <= key_rd;
    if ((st_q == ST_RANK) && (j_q == n_last)) order_q[place] <= i_q;
    if (do_fetch) begin
      src_q  <= src;
      last_q <= f_last;
    end
    if (do_nrdy) begin
      o_time_q <= '0;
      o_plan_q <= '0;
      o_src_q  <= '0;
      o_last_q <= 1'b0;
      o_stat_q <= 1'b1;
    end else if (st_q == ST_RESP) begin
      o_time_q <= IN_TIME_W'(rdata[TIME_BITS+PLAN_W-1:PLAN_W]);
      o_plan_q <= rdata[PLAN_W-1:0];
      o_src_q  <= SRC_W'(src_q);
      o_last_q <= last_q;
      o_stat_q <= 1'b0;
    end
  end

  assign out_ch.valid      = ov_q;
  assign out_ch.out_time   = o_time_q;
  assign out_ch.out_plan   = o_plan_q;
  assign out_ch.source_row = o_src_q;
  assign out_ch.last       = o_last_q;
  assign out_ch.status     = o_stat_q;

  // A response cycle always follows a served fetch.
  a_resp_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RESP) |-> $past(do_fetch))
    else $error("response cycle without a fetch");

  // The table is never marked finished while ranking is running.
  a_rank_not_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RANK) |-> !sorted_q)
    else $error("ranking while table is marked sorted");

  // A rank can never exceed the number of rows already compared.
  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RANK) |-> (rank_q <= j_q))
    else $error("rank ran past compare index");

  // Nothing is taken from the queue while sorting or answering.
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !pop_o)
    else $error("queue popped while busy");
endmodule : jrs_back
`default_nettype wire

[sv/job_row_sort_by_time_key.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// job_row_sort_by_time_key
// Loads a job-by-machine time table, orders rows by a key, returns elements.
// ----------------------------------------------------------------------------
// Channel   Dir  Carries
// in_ch     in   func, proc_time, plan_entry
// out_ch    out  out_time, out_plan, source_row, last, status
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (rule, job and machine counts)
//
// A fetch passes through a response state, for the registered read of the
// element store, before the next beat is taken. After the last load the rank
// loop compares one row key per cycle, while input beats wait in the two-entry
// queue. Reset needs no clearing pass. Either side may stall at any time; the
// output register holds a result until it is taken.
module job_row_sort_by_time_key (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  jrs_in_if.sink                               in_ch,
  jrs_out_if.source                            out_ch,
  input  wire logic                            cfg_we_i,
  input  wire logic [jrs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [jrs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import jrs_pkg::*;

  q_head_t head;
  logic    pop;

  jrs_front u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .head_o(head),
    .pop_i (pop)
  );

  jrs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .pop_o     (pop),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .out_ch    (out_ch)
  );
endmodule : job_row_sort_by_time_key
`default_nettype wire

[sim/job_row_sort_by_time_key_test.sv]
// ----------------------------------------------------------------------------
// job_row_sort_by_time_key_test
// Loads time tables of many shapes, fetches the reordered elements and checks
// every result beat against a table-sort predictor kept inside the bench.
// ----------------------------------------------------------------------------
module job_row_sort_by_time_key_test;
  import jrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Settling wait that covers the rank loop after the last load.
  localparam int SORT_SETTLE = 320;

  typedef struct {
    logic [15:0] ptime;
    logic [7:0]  plan;
    logic [3:0]  row;
    logic        last;
    logic        status;
  } fetch_beat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  jrs_in_if in_ch ();
  jrs_out_if out_ch ();

  job_row_sort_by_time_key dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Predictor state.
  logic [15:0] time_tab [DEPTH];
  logic [7:0]  plan_tab [DEPTH];
  logic [3:0]  row_seq  [MAX_JOBS];
  int unsigned loaded;
  int unsigned fetched;
  bit          table_sorted;
  logic [2:0]  rule_reg;
  logic [4:0]  jobs_reg;
  logic [4:0]  machs_reg;

  fetch_beat_t fetch_expect_q[$];
  int unsigned err_cnt;
  int unsigned items_sent;
  bit          idle_on;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int unsigned jobs_used();
    if (jobs_reg < 1) return 1;
    if (jobs_reg > MAX_JOBS) return MAX_JOBS;
    return jobs_reg;
  endfunction

  function automatic int unsigned machs_used();
    if (machs_reg < 1) return 1;
    if (machs_reg > MAX_MACHINES) return MAX_MACHINES;
    return machs_reg;
  endfunction

  function automatic void restart_table();
    loaded = 0;
    fetched = 0;
    table_sorted = 0;
  endfunction

  // Stable ascending rank of every row key; descending rules mirror it.
  function automatic void rank_rows();
    int unsigned n;
    int unsigned m;
    int unsigned rank;
    longint unsigned keys [MAX_JOBS];
    longint unsigned v;
    bit desc;
    n = jobs_used();
    m = machs_used();
    desc = (rule_reg == RULE_SUM_DESC) || (rule_reg == RULE_MIN_DESC) ||
           (rule_reg == RULE_MAX_DESC);
    for (int i = 0; i < n; i++) begin
      keys[i] = 0;
      for (int j = 0; j < m; j++) begin
        v = time_tab[i * m + j];
        case (rule_reg)
          RULE_SUM_ASC, RULE_SUM_DESC: keys[i] += v;
          RULE_MIN_ASC, RULE_MIN_DESC: if (j == 0 || v < keys[i]) keys[i] = v;
          RULE_MAX_ASC, RULE_MAX_DESC: if (j == 0 || v > keys[i]) keys[i] = v;
          default: keys[i] = 0;
        endcase
      end
    end
    for (int i = 0; i < n; i++) begin
      rank = 0;
      for (int j = 0; j < n; j++) begin
        if (keys[j] < keys[i] || (keys[j] == keys[i] && j < i)) rank++;
      end
      if (desc) row_seq[n - 1 - rank] = 4'(i);
      else row_seq[rank] = 4'(i);
    end
  endfunction

  function automatic void predict_item(op_e op, logic [15:0] ptime, logic [7:0] plan);
    int unsigned total;
    int unsigned m;
    int unsigned src;
    int unsigned addr;
    fetch_beat_t beat;
    m = machs_used();
    total = jobs_used() * m;
    if (op == OP_LOAD) begin
      if (table_sorted || loaded >= total) restart_table();
      time_tab[loaded] = ptime;
      plan_tab[loaded] = plan;
      loaded++;
      if (loaded == total) begin
        rank_rows();
        table_sorted = 1;
        fetched = 0;
      end
    end else if (!table_sorted) begin
      beat = '{ptime: '0, plan: '0, row: '0, last: 1'b0, status: 1'b1};
      fetch_expect_q.push_back(beat);
    end else begin
      src = row_seq[fetched / m];
      addr = src * m + fetched % m;
      beat = '{ptime: time_tab[addr], plan: plan_tab[addr], row: src[3:0],
               last: (fetched == total - 1), status: 1'b0};
      fetch_expect_q.push_back(beat);
      fetched = (fetched + 1 == total) ? 0 : fetched + 1;
    end
  endfunction

  task automatic send_item(op_e op, logic [15:0] ptime, logic [7:0] plan);
    in_ch.valid <= 1'b1;
    in_ch.func <= op;
    in_ch.proc_time <= ptime;
    in_ch.plan_entry <= plan;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_item(op, ptime, plan);
    items_sent++;
    if (idle_on && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // The input side goes quiet so that no beat is taken twice while waiting.
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    while (fetch_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // Registers change only with the input side quiet and the sort finished.
  task automatic write_reg(cfg_idx_e idx, logic [4:0] val);
    wait_results();
    repeat (SORT_SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SORT_RULE: rule_reg = val[2:0];
      CFG_JOB_COUNT: jobs_reg = val;
      default: machs_reg = val;
    endcase
    restart_table();
  endtask

  task automatic set_shape(logic [2:0] rule, logic [4:0] jobs, logic [4:0] machs);
    write_reg(CFG_SORT_RULE, {2'b00, rule});
    write_reg(CFG_JOB_COUNT, jobs);
    write_reg(CFG_MACHINE_COUNT, machs);
  endtask

  // Times drawn from a narrow range make ties; otherwise full range or extremes.
  function automatic logic [15:0] pick_time(int unsigned flavor);
    case (flavor)
      0: return 16'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic load_table(int unsigned flavor);
    int unsigned total;
    total = jobs_used() * machs_used();
    for (int i = 0; i < total; i++) begin
      send_item(OP_LOAD, pick_time(flavor), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic fetch_n(int unsigned cnt);
    for (int i = 0; i < cnt; i++) begin
      send_item(OP_FETCH, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_extremes();
    set_shape(RULE_SUM_ASC, 5'd2, 5'd2);
    send_item(OP_FETCH, 16'h0000, 8'h00);
    send_item(OP_LOAD, 16'hFFFF, 8'hFF);
    send_item(OP_LOAD, 16'hFFFF, 8'h00);
    // A fetch while half loaded must report not ready.
    send_item(OP_FETCH, 16'hFFFF, 8'hFF);
    send_item(OP_LOAD, 16'h0000, 8'hAA);
    send_item(OP_LOAD, 16'h0000, 8'h55);
    // Six fetches run past the end and wrap to the first element.
    fetch_n(6);
  endtask

  task automatic test_rules();
    for (int r = 0; r < 8; r++) begin
      set_shape(r[2:0], 5'd3, 5'd2);
      load_table(0);
      fetch_n(6);
    end
  endtask

  task automatic test_count_limits();
    set_shape(RULE_MAX_DESC, 5'd0, 5'd31);
    load_table(2);
    fetch_n(17);
    set_shape(RULE_MIN_ASC, 5'd31, 5'd0);
    load_table(1);
    fetch_n(16);
    set_shape(RULE_SUM_DESC, 5'd16, 5'd16);
    // The full table runs with both sides going flat out.
    idle_on = 0;
    load_table(2);
    fetch_n(256);
    idle_on = 1;
  endtask

  task automatic test_random(int unsigned goal);
    logic [4:0] jobs;
    logic [4:0] machs;
    int unsigned total;
    int unsigned flavor;
    while (items_sent < goal) begin
      jobs = ($urandom_range(99) < 5) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 4));
      machs = ($urandom_range(99) < 5) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 4));
      set_shape(3'($urandom_range(0, 7)), jobs, machs);
      total = jobs_used() * machs_used();
      flavor = $urandom_range(0, 2);
      if ($urandom_range(99) < 10) fetch_n(1);
      if ($urandom_range(99) < 10) begin
        for (int i = 0; i < total / 2; i++) begin
          send_item(OP_LOAD, pick_time(flavor), 8'($urandom_range(0, 255)));
        end
        fetch_n(1);
      end
      load_table(flavor);
      fetch_n(total + $urandom_range(0, total));
      if ($urandom_range(99) < 25) begin
        if ($urandom_range(1)) wait_results();
        load_table($urandom_range(0, 2));
        fetch_n($urandom_range(1, total + 2));
      end
    end
  endtask

  // Result side: random backpressure and the per-field comparison.
  always @(posedge clk_i) begin
    fetch_beat_t exp_beat;
    if (out_ch.valid && out_ch.ready && rst_ni) begin
      if (fetch_expect_q.size() == 0) begin
        $error("unexpected result beat");
        err_cnt++;
      end else begin
        exp_beat = fetch_expect_q.pop_front();
        if (out_ch.out_time !== exp_beat.ptime) begin
          $error("out_time exp %0d got %0d", exp_beat.ptime, out_ch.out_time);
          err_cnt++;
        end
        if (out_ch.out_plan !== exp_beat.plan) begin
          $error("out_plan exp %0d got %0d", exp_beat.plan, out_ch.out_plan);
          err_cnt++;
        end
        if (out_ch.source_row !== exp_beat.row) begin
          $error("source_row exp %0d got %0d", exp_beat.row, out_ch.source_row);
          err_cnt++;
        end
        if (out_ch.last !== exp_beat.last) begin
          $error("last exp %0d got %0d", exp_beat.last, out_ch.last);
          err_cnt++;
        end
        if (out_ch.status !== exp_beat.status) begin
          $error("status exp %0d got %0d", exp_beat.status, out_ch.status);
          err_cnt++;
        end
      end
    end
    out_ch.ready <= idle_on ? ($urandom_range(99) >= 15) : 1'b1;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    err_cnt = 0;
    items_sent = 0;
    idle_on = 1;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_SORT_RULE;
    cfg_data_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.func <= OP_LOAD;
    in_ch.proc_time <= '0;
    in_ch.plan_entry <= '0;
    rule_reg = RULE_SUM_ASC;
    jobs_reg = 5'd16;
    machs_reg = 5'd16;
    restart_table();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_rules();
    test_count_limits();
    test_random(950);
    wait_results();
    repeat (SORT_SETTLE) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : job_row_sort_by_time_key_test
